// ===== sv/bkt_pkg.sv =====
// Shared types, command and status structures, and the multiply-accumulate program.
package bkt_pkg;

   localparam int unsigned PC_WIDTH = 5;

   localparam logic [2:0] REG_QP_POS    = 3'd0;
   localparam logic [2:0] REG_QP_PER    = 3'd1;
   localparam logic [2:0] REG_MV_POS    = 3'd2;
   localparam logic [2:0] REG_MV_PER    = 3'd3;
   localparam logic [2:0] REG_INIT_POS  = 3'd4;
   localparam logic [2:0] REG_INIT_PER  = 3'd5;

   localparam logic [1:0] GAIN_LAST = 2'd3;

   localparam logic [PC_WIDTH-1:0] MAC1_FIRST = 5'd0;
   localparam logic [PC_WIDTH-1:0] MAC1_LAST  = 5'd9;
   localparam logic [PC_WIDTH-1:0] MAC2_FIRST = 5'd10;
   localparam logic [PC_WIDTH-1:0] MAC2_LAST  = 5'd19;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREDICT,
      ST_NORM,
      ST_MAC1,
      ST_DRAIN1,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MAC2,
      ST_DRAIN2,
      ST_UPDATE,
      ST_SKIP,
      ST_OUTPUT
   } state_type;

   typedef enum logic [3:0] {
      OP_A00,
      OP_A01,
      OP_A11,
      OP_B00,
      OP_B11,
      OP_K00,
      OP_K01,
      OP_K10,
      OP_K11,
      OP_EX,
      OP_EV
   } opnd_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_type;

   typedef enum logic [3:0] {
      DST_NONE,
      DST_DET,
      DST_N00,
      DST_N01,
      DST_N10,
      DST_N11,
      DST_UX,
      DST_UV,
      DST_C00,
      DST_C01,
      DST_C11
   } dst_type;

   typedef struct packed {
      opnd_type a_sel;
      opnd_type b_sel;
      acc_type  mode;
      dst_type  dst;
   } mac_op_type;

   localparam mac_op_type MAC_NOP = '{a_sel: OP_A00, b_sel: OP_A00, mode: ACC_NONE,
                                      dst: DST_NONE};

   typedef struct packed {
      logic       load_input;
      logic       predict;
      logic       norm;
      mac_op_type mac;
      logic       div_start;
      logic       div_store;
      logic [1:0] div_sel;
      logic       update;
      logic       skip;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic det_pos;
      logic div_done;
   } status_type;

   function automatic mac_op_type mac_program(input logic [PC_WIDTH-1:0] pc);
      mac_op_type op;
      op = MAC_NOP;
      unique case (pc)
         5'd0:  op = '{a_sel: OP_B00, b_sel: OP_B11, mode: ACC_LOAD, dst: DST_NONE};
         5'd1:  op = '{a_sel: OP_A01, b_sel: OP_A01, mode: ACC_SUB,  dst: DST_DET};
         5'd2:  op = '{a_sel: OP_A00, b_sel: OP_B11, mode: ACC_LOAD, dst: DST_NONE};
         5'd3:  op = '{a_sel: OP_A01, b_sel: OP_A01, mode: ACC_SUB,  dst: DST_N00};
         5'd4:  op = '{a_sel: OP_A01, b_sel: OP_B00, mode: ACC_LOAD, dst: DST_NONE};
         5'd5:  op = '{a_sel: OP_A00, b_sel: OP_A01, mode: ACC_SUB,  dst: DST_N01};
         5'd6:  op = '{a_sel: OP_A01, b_sel: OP_B11, mode: ACC_LOAD, dst: DST_NONE};
         5'd7:  op = '{a_sel: OP_A11, b_sel: OP_A01, mode: ACC_SUB,  dst: DST_N10};
         5'd8:  op = '{a_sel: OP_A11, b_sel: OP_B00, mode: ACC_LOAD, dst: DST_NONE};
         5'd9:  op = '{a_sel: OP_A01, b_sel: OP_A01, mode: ACC_SUB,  dst: DST_N11};
         5'd10: op = '{a_sel: OP_K00, b_sel: OP_EX,  mode: ACC_LOAD, dst: DST_NONE};
         5'd11: op = '{a_sel: OP_K01, b_sel: OP_EV,  mode: ACC_ADD,  dst: DST_UX};
         5'd12: op = '{a_sel: OP_K10, b_sel: OP_EX,  mode: ACC_LOAD, dst: DST_NONE};
         5'd13: op = '{a_sel: OP_K11, b_sel: OP_EV,  mode: ACC_ADD,  dst: DST_UV};
         5'd14: op = '{a_sel: OP_K00, b_sel: OP_A00, mode: ACC_LOAD, dst: DST_NONE};
         5'd15: op = '{a_sel: OP_K01, b_sel: OP_A01, mode: ACC_ADD,  dst: DST_C00};
         5'd16: op = '{a_sel: OP_K00, b_sel: OP_A01, mode: ACC_LOAD, dst: DST_NONE};
         5'd17: op = '{a_sel: OP_K01, b_sel: OP_A11, mode: ACC_ADD,  dst: DST_C01};
         5'd18: op = '{a_sel: OP_K10, b_sel: OP_A01, mode: ACC_LOAD, dst: DST_NONE};
         5'd19: op = '{a_sel: OP_K11, b_sel: OP_A11, mode: ACC_ADD,  dst: DST_C11};
         default: op = MAC_NOP;
      endcase
      return op;
   endfunction

endpackage

// ===== sv/bkt_divider.sv =====
// Serial restoring divider that forms one saturated Kalman gain entry.
module bkt_divider #(
   parameter int unsigned GAIN_FRAC_BITS = 30
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [63:0]               num,
   input  logic [63:0]                      den,
   output logic                             done,
   output logic signed [GAIN_FRAC_BITS+1:0] gain
);

   localparam int unsigned QW = GAIN_FRAC_BITS + 2;
   localparam int unsigned CW = $clog2(QW);
   localparam logic [QW-1:0] LIM = QW'((64'd1 << (GAIN_FRAC_BITS + 1)) - 64'd1);

   logic [63:0]   r_ff, r_in, d_ff, rr, dd;
   logic [QW-1:0] q_ff, q_in, q_mag;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff, neg_ff, ge;

   always_comb begin
      rr = (cnt_ff >= CW'(2)) ? {r_ff[62:0], 1'b0} : r_ff;
      dd = (cnt_ff == CW'(0)) ? {d_ff[62:0], 1'b0} : d_ff;
      ge = (rr >= dd);
      r_in = ge ? (rr - dd) : rr;
      q_in = {q_ff[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == CW'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff   <= num[63] ? $unsigned(-num) : $unsigned(num);
         d_ff   <= den;
         neg_ff <= num[63];
         q_ff   <= '0;
      end else if (busy_ff) begin
         r_ff <= r_in;
         q_ff <= q_in;
      end
   end

   always_comb begin
      if (q_ff[QW-1:QW-2] == 2'b11 || q_ff > LIM) begin
         q_mag = LIM;
      end else begin
         q_mag = q_ff;
      end
      gain = neg_ff ? -$signed(q_mag) : $signed(q_mag);
   end

   assign done = done_ff;

endmodule

// ===== sv/bkt_datapath.sv =====
// Datapath: configuration registers, filter state, shared multiplier-accumulator and divider.
module bkt_datapath #(
   parameter int unsigned FRAC_BITS      = 8,
   parameter int unsigned GAIN_FRAC_BITS = 30
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data,
   input  logic [55:0]          in_data,
   input  bkt_pkg::cmd_type     cmd,
   output bkt_pkg::status_type  status,
   output logic [55:0]          out_data
);

   localparam int unsigned KW = GAIN_FRAC_BITS + 2;

   localparam logic [63:0] QP_POS_W  = 64'd25 << FRAC_BITS;
   localparam logic [63:0] QP_PER_W  = 64'd16 << FRAC_BITS;
   localparam logic [63:0] MV_POS_W  = 64'd100 << FRAC_BITS;
   localparam logic [63:0] MV_PER_W  = 64'd36 << FRAC_BITS;
   localparam logic [63:0] INIT_PER_W = 64'd500 << FRAC_BITS;
   localparam logic [63:0] COV_POS_W = 64'd15 << FRAC_BITS;
   localparam logic [63:0] COV_PER_W = 64'd3 << FRAC_BITS;

   localparam logic signed [65:0] S40_HI = (66'sd1 <<< 39) - 66'sd1;
   localparam logic signed [65:0] S40_LO = -S40_HI - 66'sd1;
   localparam logic signed [65:0] S32_HI = (66'sd1 <<< 31) - 66'sd1;
   localparam logic signed [65:0] S32_LO = -S32_HI - 66'sd1;
   localparam logic signed [65:0] U32_HI = (66'sd1 <<< 32) - 66'sd1;
   localparam logic signed [65:0] U24_HI = (66'sd1 <<< 24) - 66'sd1;
   localparam logic signed [41:0] E_HI   = (42'sd1 <<< 31) - 42'sd1;

   function automatic logic signed [39:0] sat_s40(input logic signed [65:0] v);
      if (v > S40_HI) return S40_HI[39:0];
      if (v < S40_LO) return S40_LO[39:0];
      return v[39:0];
   endfunction

   function automatic logic signed [39:0] sat_p40(input logic signed [65:0] v);
      if (v > S40_HI) return S40_HI[39:0];
      if (v < 66'sd0) return 40'sd0;
      return v[39:0];
   endfunction

   function automatic logic signed [31:0] sat_s32(input logic signed [65:0] v);
      if (v > S32_HI) return S32_HI[31:0];
      if (v < S32_LO) return S32_LO[31:0];
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] sat_err(input logic signed [41:0] v);
      if (v > E_HI) return E_HI[31:0];
      if (v < -E_HI) return -E_HI[31:0];
      return v[31:0];
   endfunction

   function automatic logic signed [65:0] round_gain(input logic signed [63:0] v);
      logic [63:0] m;
      logic [63:0] r;
      m = v[63] ? $unsigned(-v) : $unsigned(v);
      r = (m + (64'd1 << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
      return v[63] ? -$signed({2'b00, r}) : $signed({2'b00, r});
   endfunction

   logic [23:0] qp_pos_ff, qp_per_ff, mv_pos_ff, mv_per_ff, init_per_ff;
   logic [31:0] init_pos_ff;

   logic signed [39:0] pos_est_ff, cov_pos_ff, cov_cross_ff, cov_per_ff;
   logic signed [31:0] per_est_ff;

   logic [31:0] z0_ff;
   logic [23:0] z1_ff;

   logic signed [39:0] xp_ff, p00_ff, p01_ff, p11_ff;
   logic signed [31:0] vp_ff;
   logic [40:0]        s00_ff, s11_ff;

   logic signed [31:0] a00_ff, a01_ff, a11_ff, b00_ff, b11_ff, ex_ff, ev_ff;
   logic [3:0]         shift_ff;

   logic signed [63:0] prod_ff, prod_in, acc_ff, acc_in;
   bkt_pkg::mac_op_type pend_ff;
   logic signed [63:0] det_ff, n00_ff, n01_ff, n10_ff, n11_ff;
   logic signed [63:0] ux_ff, uv_ff, c00_ff, c01_ff, c11_ff;
   logic signed [KW-1:0] k00_ff, k01_ff, k10_ff, k11_ff;

   logic [31:0] rsp_pos_ff;
   logic [23:0] rsp_per_ff;

   logic                 reload;
   logic signed [39:0]   reload_pos;
   logic signed [31:0]   reload_per;
   logic signed [39:0]   xp_in, p00_in, p01_in, p11_in;
   logic [40:0]          s00_in, s11_in;
   logic signed [40:0]   p01_x;
   logic [40:0]          p01_mag, mx, a00_t, a01_t, a11_t, b00_t, b11_t;
   logic [3:0]           shift_in;
   logic signed [31:0]   a01_in;
   logic signed [31:0]   mul_a, mul_b;
   logic signed [63:0]   div_num;
   logic                 div_done;
   logic signed [KW-1:0] div_gain;
   logic signed [39:0]   pos_new, cov_pos_new, cov_cross_new, cov_per_new;
   logic signed [31:0]   per_new;

   function automatic logic signed [31:0] pick(
      input bkt_pkg::opnd_type sel,
      input logic signed [31:0] a00, a01, a11, b00, b11, ex, ev,
      input logic signed [KW-1:0] k00, k01, k10, k11
   );
      logic signed [31:0] v;
      v = '0;
      unique case (sel)
         bkt_pkg::OP_A00: v = a00;
         bkt_pkg::OP_A01: v = a01;
         bkt_pkg::OP_A11: v = a11;
         bkt_pkg::OP_B00: v = b00;
         bkt_pkg::OP_B11: v = b11;
         bkt_pkg::OP_K00: v = 32'(k00);
         bkt_pkg::OP_K01: v = 32'(k01);
         bkt_pkg::OP_K10: v = 32'(k10);
         bkt_pkg::OP_K11: v = 32'(k11);
         bkt_pkg::OP_EX:  v = ex;
         bkt_pkg::OP_EV:  v = ev;
         default:         v = '0;
      endcase
      return v;
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         qp_pos_ff   <= QP_POS_W[23:0];
         qp_per_ff   <= QP_PER_W[23:0];
         mv_pos_ff   <= MV_POS_W[23:0];
         mv_per_ff   <= MV_PER_W[23:0];
         init_pos_ff <= 32'd0;
         init_per_ff <= INIT_PER_W[23:0];
      end else if (csr_wr) begin
         unique case (csr_index)
            bkt_pkg::REG_QP_POS:   qp_pos_ff   <= csr_data[23:0];
            bkt_pkg::REG_QP_PER:   qp_per_ff   <= csr_data[23:0];
            bkt_pkg::REG_MV_POS:   mv_pos_ff   <= csr_data[23:0];
            bkt_pkg::REG_MV_PER:   mv_per_ff   <= csr_data[23:0];
            bkt_pkg::REG_INIT_POS: init_pos_ff <= csr_data;
            bkt_pkg::REG_INIT_PER: init_per_ff <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      reload = csr_wr && (csr_index == bkt_pkg::REG_INIT_POS ||
                          csr_index == bkt_pkg::REG_INIT_PER);
      reload_pos = $signed({8'd0, (csr_index == bkt_pkg::REG_INIT_POS) ? csr_data
                                                                        : init_pos_ff});
      reload_per = $signed({8'd0, (csr_index == bkt_pkg::REG_INIT_PER) ? csr_data[23:0]
                                                                        : init_per_ff});
   end

   // Prediction.
   always_comb begin
      xp_in  = sat_s40(66'(pos_est_ff) + 66'(per_est_ff));
      p00_in = sat_p40(66'(cov_pos_ff) + (66'(cov_cross_ff) <<< 1) + 66'(cov_per_ff)
                       + $signed({42'd0, qp_pos_ff}));
      p01_in = sat_s40(66'(cov_cross_ff) + 66'(cov_per_ff));
      p11_in = sat_p40(66'(cov_per_ff) + $signed({42'd0, qp_per_ff}));
      s00_in = $unsigned(41'(p00_in)) + 41'(mv_pos_ff);
      s11_in = $unsigned(41'(p11_in)) + 41'(mv_per_ff);
   end

   // Normalizing shift and scaled matrices.
   always_comb begin
      p01_x   = 41'(p01_ff);
      p01_mag = p01_x[40] ? $unsigned(-p01_x) : $unsigned(p01_x);
      mx = (s00_ff > s11_ff) ? s00_ff : s11_ff;
      if (p01_mag > mx) mx = p01_mag;
      shift_in = 4'd0;
      for (int i = 1; i <= 10; i++) begin
         if (|(mx >> (29 + i))) shift_in = 4'(i);
      end
      a00_t = $unsigned(41'(p00_ff)) >> shift_in;
      a01_t = p01_mag >> shift_in;
      a11_t = $unsigned(41'(p11_ff)) >> shift_in;
      b00_t = s00_ff >> shift_in;
      b11_t = s11_ff >> shift_in;
      a01_in = p01_x[40] ? -$signed(a01_t[31:0]) : $signed(a01_t[31:0]);
   end

   // Shared multiplier and accumulator.
   always_comb begin
      mul_a = pick(cmd.mac.a_sel, a00_ff, a01_ff, a11_ff, b00_ff, b11_ff, ex_ff, ev_ff,
                   k00_ff, k01_ff, k10_ff, k11_ff);
      mul_b = pick(cmd.mac.b_sel, a00_ff, a01_ff, a11_ff, b00_ff, b11_ff, ex_ff, ev_ff,
                   k00_ff, k01_ff, k10_ff, k11_ff);
      prod_in = mul_a * mul_b;
      unique case (pend_ff.mode)
         bkt_pkg::ACC_NONE: acc_in = acc_ff;
         bkt_pkg::ACC_LOAD: acc_in = prod_ff;
         bkt_pkg::ACC_ADD:  acc_in = acc_ff + prod_ff;
         bkt_pkg::ACC_SUB:  acc_in = acc_ff - prod_ff;
         default:           acc_in = acc_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.div_sel)
         2'd0:    div_num = n00_ff;
         2'd1:    div_num = n01_ff;
         2'd2:    div_num = n10_ff;
         2'd3:    div_num = n11_ff;
         default: div_num = n00_ff;
      endcase
   end

   bkt_divider #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   ($unsigned(det_ff)),
      .done  (div_done),
      .gain  (div_gain)
   );

   // Correction.
   always_comb begin
      pos_new       = sat_s40(66'(xp_ff) + round_gain(ux_ff));
      per_new       = sat_s32(66'(vp_ff) + round_gain(uv_ff));
      cov_pos_new   = sat_p40(66'(p00_ff) - (round_gain(c00_ff) <<< shift_ff));
      cov_cross_new = sat_s40(66'(p01_ff) - (round_gain(c01_ff) <<< shift_ff));
      cov_per_new   = sat_p40(66'(p11_ff) - (round_gain(c11_ff) <<< shift_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_est_ff   <= 40'sd0;
         per_est_ff   <= $signed({8'd0, INIT_PER_W[23:0]});
         cov_pos_ff   <= COV_POS_W[39:0];
         cov_cross_ff <= 40'sd0;
         cov_per_ff   <= COV_PER_W[39:0];
      end else if (reload) begin
         pos_est_ff   <= reload_pos;
         per_est_ff   <= reload_per;
         cov_pos_ff   <= COV_POS_W[39:0];
         cov_cross_ff <= 40'sd0;
         cov_per_ff   <= COV_PER_W[39:0];
      end else if (cmd.update) begin
         pos_est_ff   <= pos_new;
         per_est_ff   <= per_new;
         cov_pos_ff   <= cov_pos_new;
         cov_cross_ff <= cov_cross_new;
         cov_per_ff   <= cov_per_new;
      end else if (cmd.skip) begin
         pos_est_ff   <= xp_ff;
         per_est_ff   <= vp_ff;
         cov_pos_ff   <= p00_ff;
         cov_cross_ff <= p01_ff;
         cov_per_ff   <= p11_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= bkt_pkg::MAC_NOP;
      end else begin
         pend_ff <= cmd.mac;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_input) begin
         z0_ff <= in_data[31:0];
         z1_ff <= in_data[55:32];
      end
      if (cmd.predict) begin
         xp_ff  <= xp_in;
         vp_ff  <= per_est_ff;
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p11_ff <= p11_in;
         s00_ff <= s00_in;
         s11_ff <= s11_in;
      end
      if (cmd.norm) begin
         shift_ff <= shift_in;
         a00_ff   <= $signed(a00_t[31:0]);
         a01_ff   <= a01_in;
         a11_ff   <= $signed(a11_t[31:0]);
         b00_ff   <= $signed(b00_t[31:0]);
         b11_ff   <= $signed(b11_t[31:0]);
         ex_ff    <= sat_err($signed({10'd0, z0_ff}) - 42'(xp_ff));
         ev_ff    <= sat_err($signed({18'd0, z1_ff}) - 42'(vp_ff));
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      unique case (pend_ff.dst)
         bkt_pkg::DST_NONE: ;
         bkt_pkg::DST_DET:  det_ff <= acc_in;
         bkt_pkg::DST_N00:  n00_ff <= acc_in;
         bkt_pkg::DST_N01:  n01_ff <= acc_in;
         bkt_pkg::DST_N10:  n10_ff <= acc_in;
         bkt_pkg::DST_N11:  n11_ff <= acc_in;
         bkt_pkg::DST_UX:   ux_ff  <= acc_in;
         bkt_pkg::DST_UV:   uv_ff  <= acc_in;
         bkt_pkg::DST_C00:  c00_ff <= acc_in;
         bkt_pkg::DST_C01:  c01_ff <= acc_in;
         bkt_pkg::DST_C11:  c11_ff <= acc_in;
         default: ;
      endcase
      if (cmd.div_store) begin
         unique case (cmd.div_sel)
            2'd0:    k00_ff <= div_gain;
            2'd1:    k01_ff <= div_gain;
            2'd2:    k10_ff <= div_gain;
            2'd3:    k11_ff <= div_gain;
            default: ;
         endcase
      end
      if (cmd.load_out) begin
         if (pos_est_ff < 40'sd0) begin
            rsp_pos_ff <= 32'd0;
         end else if (66'(pos_est_ff) > U32_HI) begin
            rsp_pos_ff <= U32_HI[31:0];
         end else begin
            rsp_pos_ff <= pos_est_ff[31:0];
         end
         if (per_est_ff < 32'sd0) begin
            rsp_per_ff <= 24'd0;
         end else if (66'(per_est_ff) > U24_HI) begin
            rsp_per_ff <= U24_HI[23:0];
         end else begin
            rsp_per_ff <= per_est_ff[23:0];
         end
      end
   end

   assign status.det_pos  = (det_ff > 64'sd0);
   assign status.div_done = div_done;
   assign out_data        = {rsp_per_ff, rsp_pos_ff};

endmodule

// ===== sv/bkt_ctrl.sv =====
// Controller state machine that sequences one filter update and the result register.
module bkt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  bkt_pkg::status_type status,
   output bkt_pkg::cmd_type    cmd
);

   bkt_pkg::state_type state_ff, state_in;
   logic [bkt_pkg::PC_WIDTH-1:0] pc_ff, pc_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         bkt_pkg::ST_IDLE: begin
            if (req_valid) state_in = bkt_pkg::ST_PREDICT;
         end
         bkt_pkg::ST_PREDICT: state_in = bkt_pkg::ST_NORM;
         bkt_pkg::ST_NORM: begin
            state_in = bkt_pkg::ST_MAC1;
            pc_in    = bkt_pkg::MAC1_FIRST;
         end
         bkt_pkg::ST_MAC1: begin
            if (pc_ff == bkt_pkg::MAC1_LAST) begin
               state_in = bkt_pkg::ST_DRAIN1;
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         bkt_pkg::ST_DRAIN1: state_in = bkt_pkg::ST_CHECK;
         bkt_pkg::ST_CHECK: begin
            idx_in   = 2'd0;
            state_in = status.det_pos ? bkt_pkg::ST_DIV_START : bkt_pkg::ST_SKIP;
         end
         bkt_pkg::ST_DIV_START: state_in = bkt_pkg::ST_DIV_WAIT;
         bkt_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               if (idx_ff == bkt_pkg::GAIN_LAST) begin
                  state_in = bkt_pkg::ST_MAC2;
                  pc_in    = bkt_pkg::MAC2_FIRST;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = bkt_pkg::ST_DIV_START;
               end
            end
         end
         bkt_pkg::ST_MAC2: begin
            if (pc_ff == bkt_pkg::MAC2_LAST) begin
               state_in = bkt_pkg::ST_DRAIN2;
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         bkt_pkg::ST_DRAIN2: state_in = bkt_pkg::ST_UPDATE;
         bkt_pkg::ST_UPDATE: state_in = bkt_pkg::ST_OUTPUT;
         bkt_pkg::ST_SKIP:   state_in = bkt_pkg::ST_OUTPUT;
         bkt_pkg::ST_OUTPUT: begin
            if (out_free) state_in = bkt_pkg::ST_IDLE;
         end
         default: state_in = bkt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.mac        = bkt_pkg::MAC_NOP;
      cmd.div_sel    = idx_ff;
      req_ready      = 1'b0;
      unique case (state_ff)
         bkt_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load_input = req_valid;
         end
         bkt_pkg::ST_PREDICT:   cmd.predict   = 1'b1;
         bkt_pkg::ST_NORM:      cmd.norm      = 1'b1;
         bkt_pkg::ST_MAC1:      cmd.mac       = bkt_pkg::mac_program(pc_ff);
         bkt_pkg::ST_MAC2:      cmd.mac       = bkt_pkg::mac_program(pc_ff);
         bkt_pkg::ST_DIV_START: cmd.div_start = 1'b1;
         bkt_pkg::ST_DIV_WAIT:  cmd.div_store = status.div_done;
         bkt_pkg::ST_UPDATE:    cmd.update    = 1'b1;
         bkt_pkg::ST_SKIP:      cmd.skip      = 1'b1;
         bkt_pkg::ST_OUTPUT:    cmd.load_out  = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bkt_pkg::ST_IDLE;
         pc_ff        <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         idx_ff   <= idx_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/beat_kalman_tracker.sv =====
// Top level of the two-state constant-velocity beat tracking Kalman filter.
//
// Channel   Direction  Handshake                  Payload
// req_      in         req_tvalid / req_tready    req_tdata: observation
// rsp_      out        rsp_tvalid / rsp_tready    rsp_tdata: corrected estimate
// csr_      in         csr_valid / csr_ready      csr_index, csr_data
//
// One transaction is processed at a time. A regular update's time from acceptance to result
// is set by the four gain divisions on the serial divider, one quotient bit per cycle;
// a singular innovation skips the gain divisions.
// The input is ready again in the cycle after the result is loaded, even while it waits.
// Reset is synchronous and loads the default registers and the initial state.
// A stalled result only holds the block once the next update has finished.
module beat_kalman_tracker #(
   parameter int unsigned FRAC_BITS      = 8,
   parameter int unsigned GAIN_FRAC_BITS = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // observed_position [31:0], observed_period [55:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // estimated_position [31:0], estimated_period [55:32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   bkt_pkg::cmd_type    cmd;
   bkt_pkg::status_type status;

   assign csr_ready = 1'b1;

   bkt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   bkt_datapath #(
      .FRAC_BITS      (FRAC_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_data   (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .out_data  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("Input accepted while an update was in progress.");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> !req_tready)
      else $error("Divider finished while the controller was idle.");

   a_result_on_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("Result appeared without the update finishing.");
`endif

endmodule

// ===== tb/bkt_checker.sv =====
// Checker that predicts the beat tracker's estimates and compares every result transaction.
module bkt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = 8;
   localparam int GB = 30;
   localparam longint S40_HI = (64'sd1 <<< 39) - 1;
   localparam longint S40_LO = -S40_HI - 1;
   localparam longint S32_HI = 64'sd2147483647;
   localparam longint S32_LO = -S32_HI - 1;

   typedef struct packed {
      logic [23:0] period;
      logic [31:0] position;
   } estimate_type;

   estimate_type estimate_q[$];
   logic [31:0] csr_regs[6];
   longint pos_est, per_est, c_pos, c_cross, c_per;

   function automatic longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint shift_toward_zero(longint v, int s);
      return v < 0 ? -((-v) >>> s) : (v >>> s);
   endfunction

   function automatic longint round_gain(longint v);
      longint m;
      m = v < 0 ? -v : v;
      m = (m + (64'sd1 <<< (GB - 1))) >>> GB;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint gain_quotient(longint num, longint den);
      longint lim, m, q, r;
      lim = (64'sd1 <<< (GB + 1)) - 1;
      m = num < 0 ? -num : num;
      q = m / den;
      r = m % den;
      if (q > 2) return num < 0 ? -lim : lim;
      for (int i = 0; i < GB; i++) begin
         q = q <<< 1;
         r = r <<< 1;
         if (r >= den) begin
            r -= den;
            q |= 1;
         end
      end
      return sat(num < 0 ? -q : q, -lim, lim);
   endfunction

   task automatic reload_state();
      pos_est = longint'(csr_regs[bkt_pkg::REG_INIT_POS]);
      per_est = longint'(csr_regs[bkt_pkg::REG_INIT_PER]);
      c_pos = 15 <<< FB;
      c_cross = 0;
      c_per = 3 <<< FB;
   endtask

   task automatic track_beat(input logic [55:0] obs);
      longint z0, z1, xp, vp, p00, p01, p11, s00, s11, mx;
      longint a00, a01, a11, b00, b11, det, k00, k01, k10, k11, ex, ev, sc;
      int s;
      estimate_type e;
      z0 = longint'(obs[31:0]);
      z1 = longint'(obs[55:32]);
      xp = sat(pos_est + per_est, S40_LO, S40_HI);
      vp = per_est;
      p00 = sat(c_pos + 2 * c_cross + c_per + longint'(csr_regs[bkt_pkg::REG_QP_POS]),
                0, S40_HI);
      p01 = sat(c_cross + c_per, S40_LO, S40_HI);
      p11 = sat(c_per + longint'(csr_regs[bkt_pkg::REG_QP_PER]), 0, S40_HI);
      s00 = p00 + longint'(csr_regs[bkt_pkg::REG_MV_POS]);
      s11 = p11 + longint'(csr_regs[bkt_pkg::REG_MV_PER]);
      mx = s00 > s11 ? s00 : s11;
      if ((p01 < 0 ? -p01 : p01) > mx) mx = p01 < 0 ? -p01 : p01;
      s = 0;
      while (s < 10 && (mx >>> s) >= (64'sd1 <<< 30)) s++;
      a00 = shift_toward_zero(p00, s);
      a01 = shift_toward_zero(p01, s);
      a11 = shift_toward_zero(p11, s);
      b00 = shift_toward_zero(s00, s);
      b11 = shift_toward_zero(s11, s);
      det = b00 * b11 - a01 * a01;
      if (det > 0) begin
         k00 = gain_quotient(a00 * b11 - a01 * a01, det);
         k01 = gain_quotient(a01 * b00 - a00 * a01, det);
         k10 = gain_quotient(a01 * b11 - a11 * a01, det);
         k11 = gain_quotient(a11 * b00 - a01 * a01, det);
         ex = sat(z0 - xp, -S32_HI, S32_HI);
         ev = sat(z1 - vp, -S32_HI, S32_HI);
         pos_est = sat(xp + round_gain(k00 * ex + k01 * ev), S40_LO, S40_HI);
         per_est = sat(vp + round_gain(k10 * ex + k11 * ev), S32_LO, S32_HI);
         sc = 64'sd1 <<< s;
         c_pos = sat(p00 - round_gain(k00 * a00 + k01 * a01) * sc, 0, S40_HI);
         c_cross = sat(p01 - round_gain(k00 * a01 + k01 * a11) * sc, S40_LO, S40_HI);
         c_per = sat(p11 - round_gain(k10 * a01 + k11 * a11) * sc, 0, S40_HI);
      end else begin
         pos_est = xp;
         per_est = vp;
         c_pos = p00;
         c_cross = p01;
         c_per = p11;
      end
      e.position = 32'(sat(pos_est, 0, 64'h0FFFF_FFFF));
      e.period = 24'(sat(per_est, 0, 64'hFF_FFFF));
      estimate_q.push_back(e);
   endtask

   always @(posedge clock) begin
      estimate_type got, want;
      int errs;
      errs = 0;
      if (reset) begin
         csr_regs[bkt_pkg::REG_QP_POS] = 25 << FB;
         csr_regs[bkt_pkg::REG_QP_PER] = 16 << FB;
         csr_regs[bkt_pkg::REG_MV_POS] = 100 << FB;
         csr_regs[bkt_pkg::REG_MV_PER] = 36 << FB;
         csr_regs[bkt_pkg::REG_INIT_POS] = 0;
         csr_regs[bkt_pkg::REG_INIT_PER] = 500 << FB;
         reload_state();
         estimate_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (estimate_q.size() == 0) begin
               $error("unexpected result transaction %h", rsp_tdata);
               errs++;
            end else begin
               want = estimate_q.pop_front();
               if (got.position !== want.position) begin
                  $error("estimated_position expected %0d actual %0d",
                         want.position, got.position);
                  errs++;
               end
               if (got.period !== want.period) begin
                  $error("estimated_period expected %0d actual %0d",
                         want.period, got.period);
                  errs++;
               end
            end
         end
         if (csr_valid && csr_ready && csr_index < 6) begin
            csr_regs[csr_index] = csr_index == bkt_pkg::REG_INIT_POS ? csr_data
                                                                     : {8'd0, csr_data[23:0]};
            if (csr_index == bkt_pkg::REG_INIT_POS || csr_index == bkt_pkg::REG_INIT_PER)
               reload_state();
         end
         if (req_tvalid && req_tready) track_beat(req_tdata);
         fail_count <= fail_count + errs;
      end
      pending_count <= estimate_q.size();
   end
endmodule

// ===== tb/tb_top.sv =====
// Testbench top that drives observations and register writes into the beat tracker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          fail_count;
   int          pending_count;
   int          obs_pos;
   int          rsp_wait;

   beat_kalman_tracker dut (.*);
   bkt_checker checker_i (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         rsp_wait <= int'($urandom_range(0, 14));
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_tready <= 0;
         rsp_wait <= int'($urandom_range(0, 14));
      end else if (rsp_wait != 0) begin
         if (rsp_tvalid) rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_tready <= 1;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic send_obs(input logic [31:0] pos, input logic [23:0] per, input bit gaps);
      if (gaps) repeat ($urandom_range(0, 14)) @(posedge clock);
      req_tdata <= {per, pos};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int count, input int jitter);
      for (int i = 0; i < count; i++) begin
         obs_pos += 128000 + $urandom_range(0, jitter) - jitter / 2;
         if ($urandom_range(0, 9) == 0)
            send_obs($urandom, 24'($urandom), $urandom_range(0, 1) == 1);
         else
            send_obs(obs_pos, 24'(128000 + $urandom_range(0, jitter) - jitter / 2),
                     $urandom_range(0, 3) != 0);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_obs(0, 0, 0);
      send_obs(32'hFFFF_FFFF, 24'hFF_FFFF, 0);
      send_obs(32'hFFFF_FFFF, 24'hFF_FFFF, 1);
      send_obs(0, 24'hFF_FFFF, 1);
      send_obs(32'h8000_0000, 0, 0);
      send_obs(128000, 128000, 1);
      drain();
      write_reg(bkt_pkg::REG_INIT_PER, 0);
      write_reg(3'd6, 32'h1234);
      write_reg(3'd7, 32'hFFFF_FFFF);
      send_obs(0, 0, 0);
      send_obs(5, 1, 0);
      drain();
      write_reg(bkt_pkg::REG_QP_POS, 32'hFFFF_FFFF);
      write_reg(bkt_pkg::REG_QP_PER, 32'h00FF_FFFF);
      write_reg(bkt_pkg::REG_MV_POS, 0);
      write_reg(bkt_pkg::REG_MV_PER, 0);
      write_reg(bkt_pkg::REG_INIT_POS, 32'hFFFF_FFFF);
      write_reg(bkt_pkg::REG_INIT_PER, 32'h00FF_FFFF);
      for (int i = 0; i < 12; i++) send_obs($urandom, 24'($urandom), i[0]);
      drain();
      write_reg(bkt_pkg::REG_QP_POS, 0);
      write_reg(bkt_pkg::REG_QP_PER, 0);
      write_reg(bkt_pkg::REG_INIT_POS, 0);
      write_reg(bkt_pkg::REG_INIT_PER, 1);
      send_obs(0, 0, 0);
      send_obs(1, 1, 0);
      send_obs(0, 0, 0);
      drain();
      for (int ph = 0; ph < 7; ph++) begin
         write_reg(bkt_pkg::REG_QP_POS,
                   $urandom_range(0, 1) ? $urandom_range(0, 20000) : $urandom);
         write_reg(bkt_pkg::REG_QP_PER,
                   $urandom_range(0, 1) ? $urandom_range(0, 20000) : $urandom);
         write_reg(bkt_pkg::REG_MV_POS,
                   $urandom_range(0, 1) ? $urandom_range(0, 60000) : $urandom);
         write_reg(bkt_pkg::REG_MV_PER,
                   $urandom_range(0, 1) ? $urandom_range(0, 60000) : $urandom);
         obs_pos = $urandom_range(0, 1000000);
         write_reg(bkt_pkg::REG_INIT_POS, obs_pos);
         write_reg(bkt_pkg::REG_INIT_PER,
                   ph == 6 ? 32'h00FF_FFFF : $urandom_range(1, 200000));
         random_phase(150, ph * 4000 + 2);
         drain();
      end
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
